### src/ccp_pkg.sv
`timescale 1ns / 1ps

package ccp_pkg;

  // Field widths
  localparam int COORD_W    = 20;
  localparam int CH_W       = 8;
  localparam int REQ_W      = 2;
  localparam int ST_W       = 2;
  localparam int PIX_W      = 8;
  localparam int CFG_DIM_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [ST_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [ST_W-1:0] STATUS_RANGE   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

  // Configuration reset values
  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [CH_W-1:0]      BG_RST     = 8'd32;

  // Circle kind characters
  localparam logic [CH_W-1:0] KIND_OUTLINE = 8'h63;
  localparam logic [CH_W-1:0] KIND_FILLED  = 8'h43;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_DRAW,
    CMD_READ,
    CMD_DONE
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SETUP,
    BK_SCAN,
    BK_READ
  } back_state_e;

  typedef struct packed {
    cmd_e                       op;
    logic                       filled;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [COORD_W-1:0]  r;
    logic [CH_W-1:0]            ch;
    logic [PIX_W-1:0]           px;
    logic [PIX_W-1:0]           py;
    logic [ST_W-1:0]            status;
  } cmd_t;

endpackage

### src/ccp_front.sv
`timescale 1ns / 1ps

module ccp_front import ccp_pkg::*; #(
  parameter int MAX_DIM = 256
) (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [REQ_W-1:0]           req_type_i,
  input  logic [CH_W-1:0]            circle_kind_i,
  input  logic signed [COORD_W-1:0]  center_x_i,
  input  logic signed [COORD_W-1:0]  center_y_i,
  input  logic signed [COORD_W-1:0]  radius_i,
  input  logic [CH_W-1:0]            paint_char_i,
  input  logic [PIX_W-1:0]           pixel_x_i,
  input  logic [PIX_W-1:0]           pixel_y_i,
  input  logic [((($clog2(MAX_DIM) + 1) > CFG_DIM_W) ?
                 ($clog2(MAX_DIM) + 1) : CFG_DIM_W)-1:0] w_eff_i,
  input  logic [((($clog2(MAX_DIM) + 1) > CFG_DIM_W) ?
                 ($clog2(MAX_DIM) + 1) : CFG_DIM_W)-1:0] h_eff_i,
  input  logic [CH_W-1:0]            bg_char_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output cmd_t                       q_cmd_o
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int EW = ((CW + 1) > CFG_DIM_W) ? (CW + 1) : CFG_DIM_W;

  logic kind_ok;
  logic radius_ok;
  logic empty_canvas;
  logic read_in_range;

  // Classify the request against the current canvas size
  assign kind_ok       = circle_kind_i inside {KIND_OUTLINE, KIND_FILLED};
  assign radius_ok     = !radius_i[COORD_W-1] && (radius_i != '0);
  assign empty_canvas  = (w_eff_i == '0) || (h_eff_i == '0);
  assign read_in_range = (EW'(pixel_x_i) < w_eff_i) && (EW'(pixel_y_i) < h_eff_i);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Build the command word for the back end
  always_comb begin
    q_cmd_o        = '0;
    q_cmd_o.cx     = center_x_i;
    q_cmd_o.cy     = center_y_i;
    q_cmd_o.r      = radius_i;
    q_cmd_o.px     = pixel_x_i;
    q_cmd_o.py     = pixel_y_i;
    q_cmd_o.filled = (circle_kind_i == KIND_FILLED);
    q_cmd_o.ch     = paint_char_i;
    q_cmd_o.op     = CMD_DONE;
    q_cmd_o.status = STATUS_OK;
    case (req_type_i)
      REQ_CLEAR: begin
        q_cmd_o.ch = bg_char_i;
        if (!empty_canvas) begin
          q_cmd_o.op = CMD_CLEAR;
        end
      end
      REQ_DRAW: begin
        if (!kind_ok || !radius_ok) begin
          q_cmd_o.status = STATUS_INVALID;
        end else if (!empty_canvas) begin
          q_cmd_o.op = CMD_DRAW;
        end
      end
      REQ_READ: begin
        if (read_in_range) begin
          q_cmd_o.op = CMD_READ;
        end else begin
          q_cmd_o.status = STATUS_RANGE;
        end
      end
      default: begin
        q_cmd_o.status = STATUS_INVALID;
      end
    endcase
  end

endmodule

### src/ccp_queue.sv
`timescale 1ns / 1ps

module ccp_queue import ccp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t head_o
);

  cmd_t                entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = (QPTR_W + 1)'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = (QPTR_W + 1)'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### src/ccp_back.sv
`timescale 1ns / 1ps

module ccp_back import ccp_pkg::*; #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [((($clog2(MAX_DIM) + 1) > CFG_DIM_W) ?
                 ($clog2(MAX_DIM) + 1) : CFG_DIM_W)-1:0] w_eff_i,
  input  logic [((($clog2(MAX_DIM) + 1) > CFG_DIM_W) ?
                 ($clog2(MAX_DIM) + 1) : CFG_DIM_W)-1:0] h_eff_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ST_W-1:0]  status_o,
  output logic [CH_W-1:0]  cell_char_o
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int EW    = ((CW + 1) > CFG_DIM_W) ? (CW + 1) : CFG_DIM_W;
  localparam int DXW   = (((CW + FRAC_BITS) > (COORD_W - 1)) ?
                          (CW + FRAC_BITS) : (COORD_W - 1)) + 2;
  localparam int DX2W  = 2 * DXW;
  localparam int D2W   = DX2W + 1;
  localparam int MW    = COORD_W + 1;
  localparam int PW    = 2 * MW;
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 2 ** AW;

  localparam logic signed [DXW-1:0]     ONE_DX = DXW'(2 ** FRAC_BITS);
  localparam logic signed [MW-1:0]      ONE_M  = MW'(2 ** FRAC_BITS);
  localparam logic [COORD_W-1:0]        ONE_R  = COORD_W'(2 ** FRAC_BITS);
  localparam logic [DX2W-1:0]           ONE_SQ = {{(DX2W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

  back_state_e state_q, state_d;

  // Canvas store
  logic [CH_W-1:0] cells_q [DEPTH];
  logic [CH_W-1:0] rd_data_q;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;

  // Scan and geometry state
  logic [CW-1:0]          x_q, x_d;
  logic [CW-1:0]          y_q, y_d;
  logic [1:0]             step_q, step_d;
  logic signed [DXW-1:0]  negcx_q, negcx_d;
  logic signed [DXW-1:0]  dx_q, dx_d;
  logic signed [DXW-1:0]  dy_q, dy_d;
  logic [DX2W-1:0]        cx2_q, cx2_d;
  logic [DX2W-1:0]        dx2_q, dx2_d;
  logic [DX2W-1:0]        dy2_q, dy2_d;
  logic [DX2W-1:0]        r2_q, r2_d;
  logic [DX2W-1:0]        core2_q, core2_d;
  logic                   has_core_q, has_core_d;
  logic                   filled_q, filled_d;
  logic                   clear_q, clear_d;
  logic [CH_W-1:0]        ch_q, ch_d;
  logic signed [COORD_W-1:0] cy_q, cy_d;
  logic signed [COORD_W-1:0] r_q, r_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  logic [ST_W-1:0]  status_q, status_d;
  logic [CH_W-1:0]  cell_q, cell_d;

  logic                   out_free;
  logic signed [MW-1:0]   mul_a;
  logic signed [PW-1:0]   mul_p;
  logic [DX2W-1:0]        mul_sq;
  logic [D2W-1:0]         d2;
  logic                   in_disc, core;
  logic                   x_last, y_last;
  logic signed [D2W-1:0]  dx2_step, dy2_step;
  logic [EW-1:0]          px_ext, py_ext;

  assign out_free = !out_valid_q || !out_stall_i;

  // Shared squaring unit for setup; the negated centre squares the same
  always_comb begin
    case (step_q)
      2'd0:    mul_a = MW'(negcx_q);
      2'd1:    mul_a = MW'(cy_q);
      2'd2:    mul_a = MW'(r_q);
      default: mul_a = MW'(MW'(r_q) - ONE_M);
    endcase
  end

  assign mul_p  = mul_a * mul_a;
  assign mul_sq = DX2W'(unsigned'(mul_p));

  // Distance tests for the current cell
  assign d2      = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign in_disc = (d2 <= {1'b0, r2_q});
  assign core    = has_core_q && (d2 <= {1'b0, core2_q});
  assign x_last  = (EW'(EW'(x_q) + 1'b1) == w_eff_i);
  assign y_last  = (EW'(EW'(y_q) + 1'b1) == h_eff_i);

  // Incremental squares: (d + 1)^2 = d^2 + 2d + 1 in fixed point
  assign dx2_step = D2W'($signed({1'b0, dx2_q}) + (D2W'(dx_q) <<< (FRAC_BITS + 1))
                    + $signed({1'b0, ONE_SQ}));
  assign dy2_step = D2W'($signed({1'b0, dy2_q}) + (D2W'(dy_q) <<< (FRAC_BITS + 1))
                    + $signed({1'b0, ONE_SQ}));

  assign wr_en   = (state_q == BK_SCAN) && (clear_q || (in_disc && (filled_q || !core)));
  assign wr_addr = {y_q, x_q};
  assign px_ext  = EW'(cmd_i.px);
  assign py_ext  = EW'(cmd_i.py);
  assign rd_addr = {py_ext[CW-1:0], px_ext[CW-1:0]};

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    step_d      = step_q;
    negcx_d     = negcx_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    cx2_d       = cx2_q;
    dx2_d       = dx2_q;
    dy2_d       = dy2_q;
    r2_d        = r2_q;
    core2_d     = core2_q;
    has_core_d  = has_core_q;
    filled_d    = filled_q;
    clear_d     = clear_q;
    ch_d        = ch_q;
    cy_d        = cy_q;
    r_d         = r_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    cell_d      = cell_q;
    cmd_pop_o   = 1'b0;
    rd_en       = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o  = 1'b1;
          x_d        = '0;
          y_d        = '0;
          step_d     = '0;
          negcx_d    = -DXW'(cmd_i.cx);
          dx_d       = -DXW'(cmd_i.cx);
          dy_d       = -DXW'(cmd_i.cy);
          cy_d       = cmd_i.cy;
          r_d        = cmd_i.r;
          has_core_d = (cmd_i.r >= ONE_R);
          filled_d   = cmd_i.filled;
          ch_d       = cmd_i.ch;
          clear_d    = 1'b0;
          case (cmd_i.op)
            CMD_CLEAR: begin
              clear_d = 1'b1;
              state_d = BK_SCAN;
            end
            CMD_DRAW: begin
              state_d = BK_SETUP;
            end
            CMD_READ: begin
              rd_en   = 1'b1;
              state_d = BK_READ;
            end
            default: begin
              out_valid_d = 1'b1;
              status_d    = cmd_i.status;
              cell_d      = '0;
            end
          endcase
        end
      end

      BK_SETUP: begin
        // Square centre, radius and inner radius, one per cycle
        step_d = 2'(step_q + 1'b1);
        case (step_q)
          2'd0: begin
            cx2_d = mul_sq;
            dx2_d = mul_sq;
          end
          2'd1: dy2_d = mul_sq;
          2'd2: r2_d  = mul_sq;
          default: begin
            core2_d = mul_sq;
            state_d = BK_SCAN;
          end
        endcase
      end

      BK_SCAN: begin
        if (x_last) begin
          x_d   = '0;
          dx_d  = negcx_q;
          dx2_d = cx2_q;
          if (y_last) begin
            out_valid_d = 1'b1;
            status_d    = STATUS_OK;
            cell_d      = '0;
            state_d     = BK_IDLE;
          end else begin
            y_d   = CW'(y_q + 1'b1);
            dy_d  = dy_q + ONE_DX;
            dy2_d = dy2_step[DX2W-1:0];
          end
        end else begin
          x_d   = CW'(x_q + 1'b1);
          dx_d  = dx_q + ONE_DX;
          dx2_d = dx2_step[DX2W-1:0];
        end
      end

      BK_READ: begin
        out_valid_d = 1'b1;
        status_d    = STATUS_OK;
        cell_d      = rd_data_q;
        state_d     = BK_IDLE;
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    step_q     <= step_d;
    negcx_q    <= negcx_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    cx2_q      <= cx2_d;
    dx2_q      <= dx2_d;
    dy2_q      <= dy2_d;
    r2_q       <= r2_d;
    core2_q    <= core2_d;
    has_core_q <= has_core_d;
    filled_q   <= filled_d;
    clear_q    <= clear_d;
    ch_q       <= ch_d;
    cy_q       <= cy_d;
    r_q        <= r_d;
    status_q   <= status_d;
    cell_q     <= cell_d;
  end

  // Canvas memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cells_q[wr_addr] <= ch_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= cells_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign cell_char_o = cell_q;

endmodule

### src/circle_canvas_painter_top.sv
`timescale 1ns / 1ps

// Character canvas that clears, paints filled or outline circles, and reads
// single cells. Requests pass a front end that checks them and sorts out
// errors and out-of-range reads, then a two-word queue, then a back end that
// owns the canvas memory and sends one result word per request. The back end
// takes one request at a time; a draw first squares the centre, the radius
// and the inner radius on its single squaring multiplier, then a clear or a
// draw visits every cell in use, one cell per cycle, and writes those that
// the clear or the circle covers. A read goes through the registered memory
// port. The canvas holds no known value after reset: clear it before
// reading. Write the size and background registers only while no request
// is in flight.
module circle_canvas_painter_top import ccp_pkg::*; #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [REQ_W-1:0]           req_type_i,
  input  logic [CH_W-1:0]            circle_kind_i,
  input  logic signed [COORD_W-1:0]  center_x_i,
  input  logic signed [COORD_W-1:0]  center_y_i,
  input  logic signed [COORD_W-1:0]  radius_i,
  input  logic [CH_W-1:0]            paint_char_i,
  input  logic [PIX_W-1:0]           pixel_x_i,
  input  logic [PIX_W-1:0]           pixel_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ST_W-1:0]            status_o,
  output logic [CH_W-1:0]            cell_char_o
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int EW = ((CW + 1) > CFG_DIM_W) ? (CW + 1) : CFG_DIM_W;

  logic [CFG_DIM_W-1:0] width_q;
  logic [CFG_DIM_W-1:0] height_q;
  logic [CH_W-1:0]      bg_q;
  logic [EW-1:0]        w_eff, h_eff;

  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_push_cmd, q_head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      bg_q     <= BG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT: height_q <= cfg_wdata_i;
        CFG_BG:     bg_q     <= cfg_wdata_i[CH_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp the size registers to the canvas store
  assign w_eff = (EW'(width_q) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(width_q);
  assign h_eff = (EW'(height_q) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(height_q);

  ccp_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .circle_kind_i (circle_kind_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_i      (radius_i),
    .paint_char_i  (paint_char_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .w_eff_i       (w_eff),
    .h_eff_i       (h_eff),
    .bg_char_i     (bg_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_push_cmd)
  );

  ccp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .head_o     (q_head)
  );

  ccp_back #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .w_eff_i     (w_eff),
    .h_eff_i     (h_eff),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .cell_char_o (cell_char_o)
  );

endmodule
